// ===== sv/cts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, token codes and keyword table for the C subset token scanner.
// Depends on nothing; used by c_subset_token_scanner.
package cts_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int KW_COUNT             = 9;
    localparam int KW_BYTES             = 6;
    localparam int RESULT_DEPTH         = 4;

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
    localparam logic [62:0] VAL_MAX = {63{1'b1}};

    // Token kinds
    localparam logic [4:0] TK_END          = 5'd0;
    localparam logic [4:0] TK_IDENT        = 5'd10;
    localparam logic [4:0] TK_FLOAT        = 5'd11;
    localparam logic [4:0] TK_INT          = 5'd12;
    localparam logic [4:0] TK_LPAREN       = 5'd13;
    localparam logic [4:0] TK_RPAREN       = 5'd14;
    localparam logic [4:0] TK_LBRACE       = 5'd15;
    localparam logic [4:0] TK_RBRACE       = 5'd16;
    localparam logic [4:0] TK_SEMI         = 5'd17;
    localparam logic [4:0] TK_COMMA        = 5'd18;
    localparam logic [4:0] TK_PLUS         = 5'd19;
    localparam logic [4:0] TK_MINUS        = 5'd20;
    localparam logic [4:0] TK_STAR         = 5'd21;
    localparam logic [4:0] TK_SLASH        = 5'd22;
    localparam logic [4:0] TK_ASSIGN       = 5'd23;
    localparam logic [4:0] TK_EQUALS       = 5'd24;
    localparam logic [4:0] TK_NOTEQUAL     = 5'd25;
    localparam logic [4:0] TK_LESS         = 5'd26;
    localparam logic [4:0] TK_LESSEQUAL    = 5'd27;
    localparam logic [4:0] TK_GREATER      = 5'd28;
    localparam logic [4:0] TK_GREATEREQUAL = 5'd29;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNEXPECT = 2'd1;
    localparam logic [1:0] ERR_EXPONENT = 2'd2;

    // Scan modes, one-hot
    typedef enum logic [13:0] {
        M_IDLE    = 14'b00_0000_0000_0001,
        M_IDENT   = 14'b00_0000_0000_0010,
        M_INT     = 14'b00_0000_0000_0100,
        M_FRAC    = 14'b00_0000_0000_1000,
        M_DOT     = 14'b00_0000_0001_0000,
        M_EXP     = 14'b00_0000_0010_0000,
        M_EXPSIGN = 14'b00_0000_0100_0000,
        M_EXPDIG  = 14'b00_0000_1000_0000,
        M_SLASH   = 14'b00_0001_0000_0000,
        M_EQ      = 14'b00_0010_0000_0000,
        M_BANG    = 14'b00_0100_0000_0000,
        M_LT      = 14'b00_1000_0000_0000,
        M_GT      = 14'b01_0000_0000_0000,
        M_COMMENT = 14'b10_0000_0000_0000
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [62:0] val;
        logic [1:0]  err;
        logic        last;
    } t_result;

    // Keyword text, first byte in the top byte, zero padded
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        {"short",  8'h00},
        {"int",   24'h00_0000},
        {"float",  8'h00},
        "double",
        {"void",  16'h0000},
        "return",
        {"if",    32'h0000_0000},
        {"else",  16'h0000},
        {"while",  8'h00}
    };
    localparam logic [31:0] KW_LEN [KW_COUNT] = '{
        32'd5, 32'd3, 32'd5, 32'd6, 32'd4, 32'd6, 32'd2, 32'd4, 32'd5
    };

    // Classify a finished word as keyword or identifier
    function automatic logic [4:0] word_kind(input logic [47:0] buf_text,
                                             input logic [31:0] len);
        logic [4:0] k;
        k = TK_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && buf_text == KW_TEXT[i]) begin
                k = 5'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic t_result mk_result(input logic [4:0]  kind,
                                          input logic [31:0] start,
                                          input logic [31:0] len,
                                          input logic [62:0] val,
                                          input logic [1:0]  err);
        t_result r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.val   = val;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/c_subset_token_scanner.sv =====
`timescale 1ns / 1ps
// Streaming lexer for a small C subset: one source byte in, up to two tokens out.
// Depends on cts_pkg for token codes, scan modes and the keyword table.
//
// A token is written into the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while o_ready is high; the scan step is one pass
// of logic on the state registers, and results drain through a four-entry queue,
// one per cycle while i_ready is high. o_ready drops while fewer than two queue places are free.
// Reset (synchronous, active low) returns the scanner to idle, position zero,
// error cleared and the result queue empty.
module c_subset_token_scanner #(
    parameter int POSITION_BITS = cts_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [31:0] o_start_offset,
    output logic [31:0] o_length,
    output logic [62:0] o_int_value,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);

    localparam int QA = $clog2(cts_pkg::RESULT_DEPTH);

    cts_pkg::t_mode           r_mode, n_mode;
    logic [47:0]              r_buf, n_buf;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [31:0]              r_len, n_len;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [62:0]              r_acc, n_acc;
    logic                     r_failed, n_failed;

    cts_pkg::t_result r_q [cts_pkg::RESULT_DEPTH];
    logic [QA-1:0]    r_wr, r_rd;
    logic [QA:0]      r_cnt;

    logic             accept, pop;
    logic             is_end, dig, alpha, space, consumed;
    logic             p_valid, s_valid;
    cts_pkg::t_result p_res, s_res, res0, res1;
    logic [1:0]       n_push;
    logic [31:0]      len_grow;
    logic [31:0]      start32, pos32;
    logic [66:0]      acc_next;
    logic [4:0]       one_kind;

    assign accept = i_valid && o_ready;
    assign pop    = o_valid && i_ready;
    assign o_ready = (r_cnt <= (QA+1)'(cts_pkg::RESULT_DEPTH - 2));

    // Classify the incoming byte
    assign is_end  = i_kind || (i_ch == 8'h00);
    assign dig     = !is_end && (i_ch >= "0") && (i_ch <= "9");
    assign alpha   = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
    assign space   = (i_ch == " ") || ((i_ch >= 8'd9) && (i_ch <= 8'd13));

    assign len_grow = (r_len == cts_pkg::LEN_MAX) ? r_len : r_len + 32'd1;
    assign start32  = 32'(r_start);
    assign pos32    = 32'(r_pos);
    assign acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 67'(i_ch - "0");

    always_comb begin
        case (r_mode)
            cts_pkg::M_LT: one_kind = cts_pkg::TK_LESS;
            cts_pkg::M_GT: one_kind = cts_pkg::TK_GREATER;
            default:       one_kind = cts_pkg::TK_ASSIGN;
        endcase
    end

    // Scan step: finish or extend the pending token, then start a new one
    always_comb begin
        n_mode   = r_mode;
        n_buf    = r_buf;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_failed = r_failed;
        consumed = 1'b0;
        p_valid  = 1'b0;
        s_valid  = 1'b0;
        p_res    = cts_pkg::mk_result(cts_pkg::TK_END, start32, r_len, '0, cts_pkg::ERR_NONE);
        s_res    = cts_pkg::mk_result(cts_pkg::TK_END, pos32, '0, '0, cts_pkg::ERR_NONE);

        case (r_mode)
            cts_pkg::M_IDENT: begin
                if (!is_end && (alpha || dig || i_ch == "_")) begin
                    for (int i = 0; i < cts_pkg::KW_BYTES; i++) begin
                        if (r_len == 32'(i)) begin
                            n_buf[47-8*i -: 8] = i_ch;
                        end
                    end
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else begin
                    p_valid    = 1'b1;
                    p_res.kind = cts_pkg::word_kind(r_buf, r_len);
                end
            end
            cts_pkg::M_INT: begin
                if (dig) begin
                    n_acc    = (acc_next > 67'(cts_pkg::VAL_MAX)) ? cts_pkg::VAL_MAX
                                                                   : acc_next[62:0];
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else if (!is_end && i_ch == ".") begin
                    n_mode   = cts_pkg::M_FRAC;
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else if (!is_end && (i_ch == "e" || i_ch == "E")) begin
                    n_mode   = cts_pkg::M_EXP;
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else begin
                    p_valid    = 1'b1;
                    p_res.kind = cts_pkg::TK_INT;
                    p_res.val  = r_acc;
                end
            end
            cts_pkg::M_FRAC: begin
                if (dig) begin
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else if (!is_end && (i_ch == "e" || i_ch == "E")) begin
                    n_mode   = cts_pkg::M_EXP;
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else begin
                    p_valid    = 1'b1;
                    p_res.kind = cts_pkg::TK_FLOAT;
                end
            end
            cts_pkg::M_DOT: begin
                consumed = 1'b1;
                if (dig) begin
                    n_mode = cts_pkg::M_FRAC;
                    n_len  = len_grow;
                end else begin
                    p_valid   = 1'b1;
                    p_res.err = cts_pkg::ERR_UNEXPECT;
                    n_failed  = 1'b1;
                end
            end
            cts_pkg::M_EXP: begin
                consumed = 1'b1;
                if (!is_end && (i_ch == "+" || i_ch == "-")) begin
                    n_mode = cts_pkg::M_EXPSIGN;
                    n_len  = len_grow;
                end else if (dig) begin
                    n_mode = cts_pkg::M_EXPDIG;
                    n_len  = len_grow;
                end else begin
                    p_valid   = 1'b1;
                    p_res.err = cts_pkg::ERR_EXPONENT;
                    n_failed  = 1'b1;
                end
            end
            cts_pkg::M_EXPSIGN: begin
                consumed = 1'b1;
                if (dig) begin
                    n_mode = cts_pkg::M_EXPDIG;
                    n_len  = len_grow;
                end else begin
                    p_valid   = 1'b1;
                    p_res.err = cts_pkg::ERR_EXPONENT;
                    n_failed  = 1'b1;
                end
            end
            cts_pkg::M_EXPDIG: begin
                if (dig) begin
                    n_len    = len_grow;
                    consumed = 1'b1;
                end else begin
                    p_valid    = 1'b1;
                    p_res.kind = cts_pkg::TK_FLOAT;
                end
            end
            cts_pkg::M_SLASH: begin
                if (!is_end && i_ch == "/") begin
                    n_mode   = cts_pkg::M_COMMENT;
                    consumed = 1'b1;
                end else begin
                    p_valid    = 1'b1;
                    p_res.kind = cts_pkg::TK_SLASH;
                    p_res.len  = 32'd1;
                end
            end
            cts_pkg::M_EQ, cts_pkg::M_LT, cts_pkg::M_GT: begin
                p_valid = 1'b1;
                if (!is_end && i_ch == "=") begin
                    p_res.kind = one_kind + 5'd1;
                    p_res.len  = 32'd2;
                    n_mode     = cts_pkg::M_IDLE;
                    consumed   = 1'b1;
                end else begin
                    p_res.kind = one_kind;
                    p_res.len  = 32'd1;
                end
            end
            cts_pkg::M_BANG: begin
                p_valid  = 1'b1;
                consumed = 1'b1;
                if (!is_end && i_ch == "=") begin
                    p_res.kind = cts_pkg::TK_NOTEQUAL;
                    p_res.len  = 32'd2;
                    n_mode     = cts_pkg::M_IDLE;
                end else begin
                    p_res.err = cts_pkg::ERR_UNEXPECT;
                    n_failed  = 1'b1;
                end
            end
            cts_pkg::M_COMMENT: begin
                if (!is_end) begin
                    consumed = 1'b1;
                    if (i_ch == 8'h0A) begin
                        n_mode = cts_pkg::M_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase

        // Byte not taken by the pending token: end of source or a new token
        if (!consumed) begin
            n_mode = cts_pkg::M_IDLE;
            if (is_end) begin
                s_valid = 1'b1;
                n_buf   = '0;
                n_start = '0;
                n_len   = '0;
                n_acc   = '0;
            end else if (!space) begin
                n_start = r_pos;
                n_len   = 32'd1;
                if (alpha || i_ch == "_") begin
                    n_mode = cts_pkg::M_IDENT;
                    n_buf  = {i_ch, 40'h0};
                end else if (dig) begin
                    n_mode = cts_pkg::M_INT;
                    n_acc  = 63'(i_ch - "0");
                end else begin
                    s_res.len = 32'd1;
                    case (i_ch)
                        ".": n_mode = cts_pkg::M_DOT;
                        "/": n_mode = cts_pkg::M_SLASH;
                        "=": n_mode = cts_pkg::M_EQ;
                        "<": n_mode = cts_pkg::M_LT;
                        ">": n_mode = cts_pkg::M_GT;
                        "!": n_mode = cts_pkg::M_BANG;
                        "(": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_LPAREN; end
                        ")": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_RPAREN; end
                        "{": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_LBRACE; end
                        "}": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_RBRACE; end
                        ";": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_SEMI;   end
                        ",": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_COMMA;  end
                        "+": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_PLUS;   end
                        "-": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_MINUS;  end
                        "*": begin s_valid = 1'b1; s_res.kind = cts_pkg::TK_STAR;   end
                        default: begin
                            s_valid   = 1'b1;
                            s_res.err = cts_pkg::ERR_UNEXPECT;
                            n_failed  = 1'b1;
                        end
                    endcase
                end
            end
        end

        // Advance the byte position; end of source restarts it
        if (!consumed && is_end) begin
            n_pos = '0;
        end else if (!is_end && !n_failed) begin
            n_pos = r_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        end
    end

    // Pack up to two results in order and mark the final one
    always_comb begin
        res0      = p_valid ? p_res : s_res;
        res1      = s_res;
        res0.last = !(p_valid && s_valid);
        res1.last = 1'b1;
        n_push    = {1'b0, p_valid} + {1'b0, s_valid};
    end

    // Hold scanner state; a failed scanner drops every item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= cts_pkg::M_IDLE;
            r_buf    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_acc    <= '0;
            r_failed <= 1'b0;
        end else if (accept && !r_failed) begin
            r_mode   <= n_mode;
            r_buf    <= n_buf;
            r_start  <= n_start;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_failed <= n_failed;
        end
    end

    // Result queue payload
    always_ff @(posedge i_clk) begin
        if (accept && !r_failed) begin
            if (n_push != 2'd0) begin
                r_q[r_wr] <= res0;
            end
            if (n_push == 2'd2) begin
                r_q[r_wr + QA'(1)] <= res1;
            end
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept && !r_failed) begin
                r_wr <= r_wr + QA'(n_push);
            end
            if (pop) begin
                r_rd <= r_rd + QA'(1);
            end
            r_cnt <= r_cnt + ((accept && !r_failed) ? (QA+1)'(n_push) : '0)
                           - (QA+1)'(pop);
        end
    end

    assign o_valid        = (r_cnt != '0);
    assign o_token_kind   = r_q[r_rd].kind;
    assign o_start_offset = r_q[r_rd].start;
    assign o_length       = r_q[r_rd].len;
    assign o_int_value    = r_q[r_rd].val;
    assign o_error_code   = r_q[r_rd].err;
    assign o_last_of_run  = r_q[r_rd].last;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for c_subset_token_scanner: feeds random C-subset sources byte by
// byte under random stalls and checks every token against a behavioural scanner model.
// Depends on cts_pkg and the scanner RTL.
module tb;

    // Behavioural scanner and the queue of tokens it still waits for
    class token_scoreboard;
        cts_pkg::t_mode   mode;
        logic [7:0]       word [cts_pkg::KW_BYTES];
        logic [31:0]      tok_start;
        logic [31:0]      tok_len;
        logic [31:0]      pos;
        logic [62:0]      acc;
        bit               failed;
        cts_pkg::t_result fresh [$];
        cts_pkg::t_result awaited [$];
        string            keywords [cts_pkg::KW_COUNT];
        int               mismatches;

        function new();
            keywords = '{"short", "int", "float", "double", "void", "return", "if", "else",
                         "while"};
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = cts_pkg::M_IDLE;
            foreach (word[i]) word[i] = 8'h00;
            tok_start = '0;
            tok_len = '0;
            pos = '0;
            acc = '0;
            failed = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        // Hold at most two tokens per byte
        function void emit(logic [4:0] kind, logic [31:0] start, logic [31:0] len,
                           logic [62:0] val, logic [1:0] err);
            cts_pkg::t_result r;
            if (fresh.size() >= 2) return;
            r.kind = kind;
            r.start = start;
            r.len = len;
            r.val = val;
            r.err = err;
            r.last = 1'b0;
            fresh.insert(fresh.size(), r);
        endfunction

        function void abort(logic [1:0] err);
            emit(cts_pkg::TK_END, tok_start, tok_len, '0, err);
            failed = 1'b1;
        endfunction

        function void grow();
            if (tok_len != cts_pkg::LEN_MAX) tok_len++;
        endfunction

        function void open(cts_pkg::t_mode m);
            mode = m;
            tok_start = pos;
            tok_len = 32'd1;
        endfunction

        // Keyword code of the finished word, or identifier
        function logic [4:0] word_code();
            logic [4:0] code;
            bit same;
            code = cts_pkg::TK_IDENT;
            if (tok_len <= 32'd6) begin
                for (int k = 0; k < cts_pkg::KW_COUNT; k++) begin
                    if (keywords[k].len() == tok_len) begin
                        same = 1'b1;
                        for (int j = 0; j < keywords[k].len(); j++) begin
                            if (word[j] != keywords[k][j]) same = 1'b0;
                        end
                        if (same) code = 5'(k + 1);
                    end
                end
            end
            return code;
        endfunction

        // Offer the byte to the pending token; return 1 if it was consumed
        function bit extend(logic [7:0] c, bit fin);
            bit dig;
            logic [63:0] d;
            logic [63:0] wide;
            logic [4:0] one;
            logic [4:0] two;
            dig = !fin && c >= "0" && c <= "9";
            d = 64'(c) - 64'h30;
            case (mode)
                cts_pkg::M_IDENT: begin
                    if (!fin && (is_letter(c) || dig || c == "_")) begin
                        if (tok_len < 32'd6) word[tok_len] = c;
                        grow();
                        return 1'b1;
                    end
                    emit(word_code(), tok_start, tok_len, '0, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_INT: begin
                    if (dig) begin
                        // saturate at the signed 64-bit maximum
                        wide = {1'b0, acc};
                        acc = (wide > (64'h7FFF_FFFF_FFFF_FFFF - d) / 64'd10) ?
                              cts_pkg::VAL_MAX : 63'(wide * 64'd10 + d);
                        grow();
                        return 1'b1;
                    end
                    if (!fin && c == ".") begin
                        mode = cts_pkg::M_FRAC;
                        grow();
                        return 1'b1;
                    end
                    if (!fin && (c == "e" || c == "E")) begin
                        mode = cts_pkg::M_EXP;
                        grow();
                        return 1'b1;
                    end
                    emit(cts_pkg::TK_INT, tok_start, tok_len, acc, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_FRAC: begin
                    if (dig) begin
                        grow();
                        return 1'b1;
                    end
                    if (!fin && (c == "e" || c == "E")) begin
                        mode = cts_pkg::M_EXP;
                        grow();
                        return 1'b1;
                    end
                    emit(cts_pkg::TK_FLOAT, tok_start, tok_len, '0, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_DOT: begin
                    if (dig) begin
                        mode = cts_pkg::M_FRAC;
                        grow();
                        return 1'b1;
                    end
                    abort(cts_pkg::ERR_UNEXPECT);
                    return 1'b1;
                end
                cts_pkg::M_EXP: begin
                    if (!fin && (c == "+" || c == "-")) begin
                        mode = cts_pkg::M_EXPSIGN;
                        grow();
                        return 1'b1;
                    end
                    if (dig) begin
                        mode = cts_pkg::M_EXPDIG;
                        grow();
                        return 1'b1;
                    end
                    abort(cts_pkg::ERR_EXPONENT);
                    return 1'b1;
                end
                cts_pkg::M_EXPSIGN: begin
                    if (dig) begin
                        mode = cts_pkg::M_EXPDIG;
                        grow();
                        return 1'b1;
                    end
                    abort(cts_pkg::ERR_EXPONENT);
                    return 1'b1;
                end
                cts_pkg::M_EXPDIG: begin
                    if (dig) begin
                        grow();
                        return 1'b1;
                    end
                    emit(cts_pkg::TK_FLOAT, tok_start, tok_len, '0, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_SLASH: begin
                    if (!fin && c == "/") begin
                        mode = cts_pkg::M_COMMENT;
                        return 1'b1;
                    end
                    emit(cts_pkg::TK_SLASH, tok_start, 32'd1, '0, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_EQ, cts_pkg::M_LT, cts_pkg::M_GT: begin
                    if (mode == cts_pkg::M_EQ) begin
                        one = cts_pkg::TK_ASSIGN;
                        two = cts_pkg::TK_EQUALS;
                    end else if (mode == cts_pkg::M_LT) begin
                        one = cts_pkg::TK_LESS;
                        two = cts_pkg::TK_LESSEQUAL;
                    end else begin
                        one = cts_pkg::TK_GREATER;
                        two = cts_pkg::TK_GREATEREQUAL;
                    end
                    if (!fin && c == "=") begin
                        emit(two, tok_start, 32'd2, '0, cts_pkg::ERR_NONE);
                        mode = cts_pkg::M_IDLE;
                        return 1'b1;
                    end
                    emit(one, tok_start, 32'd1, '0, cts_pkg::ERR_NONE);
                end
                cts_pkg::M_BANG: begin
                    if (!fin && c == "=") begin
                        emit(cts_pkg::TK_NOTEQUAL, tok_start, 32'd2, '0, cts_pkg::ERR_NONE);
                        mode = cts_pkg::M_IDLE;
                        return 1'b1;
                    end
                    abort(cts_pkg::ERR_UNEXPECT);
                    return 1'b1;
                end
                cts_pkg::M_COMMENT: begin
                    if (!fin) begin
                        if (c == 8'h0A) mode = cts_pkg::M_IDLE;
                        return 1'b1;
                    end
                end
                default: ;
            endcase
            mode = cts_pkg::M_IDLE;
            return 1'b0;
        endfunction

        // Begin a new token from an idle scanner
        function void start(logic [7:0] c);
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
            if (is_letter(c) || c == "_") begin
                open(cts_pkg::M_IDENT);
                foreach (word[i]) word[i] = 8'h00;
                word[0] = c;
                return;
            end
            if (c >= "0" && c <= "9") begin
                open(cts_pkg::M_INT);
                acc = 63'(c - 8'h30);
                return;
            end
            case (c)
                ".": open(cts_pkg::M_DOT);
                "/": open(cts_pkg::M_SLASH);
                "=": open(cts_pkg::M_EQ);
                "<": open(cts_pkg::M_LT);
                ">": open(cts_pkg::M_GT);
                "!": open(cts_pkg::M_BANG);
                "(": emit(cts_pkg::TK_LPAREN, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                ")": emit(cts_pkg::TK_RPAREN, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                "{": emit(cts_pkg::TK_LBRACE, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                "}": emit(cts_pkg::TK_RBRACE, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                ";": emit(cts_pkg::TK_SEMI, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                ",": emit(cts_pkg::TK_COMMA, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                "+": emit(cts_pkg::TK_PLUS, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                "-": emit(cts_pkg::TK_MINUS, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                "*": emit(cts_pkg::TK_STAR, pos, 32'd1, '0, cts_pkg::ERR_NONE);
                default: begin
                    tok_start = pos;
                    tok_len = 32'd1;
                    abort(cts_pkg::ERR_UNEXPECT);
                end
            endcase
        endfunction

        // Note an accepted byte and queue the tokens it completes
        function void note_byte(bit k, logic [7:0] c);
            bit fin;
            cts_pkg::t_result r;
            fin = k || c == 8'h00;
            fresh.delete();
            if (failed) return;
            if (!extend(c, fin) && !failed) begin
                if (fin) begin
                    emit(cts_pkg::TK_END, pos, '0, '0, cts_pkg::ERR_NONE);
                    clear_state();
                end else begin
                    start(c);
                end
            end
            if (!fin && !failed) pos++;
            foreach (fresh[i]) begin
                r = fresh[i];
                r.last = (i == fresh.size() - 1);
                awaited.insert(awaited.size(), r);
            end
        endfunction

        function void cmp(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 20)
                    $error("%s: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        // Check a delivered token against the oldest one awaited
        function void check_token(cts_pkg::t_result got);
            cts_pkg::t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 20)
                    $error("token with none awaited: kind %0d start %0d", got.kind, got.start);
                return;
            end
            want = awaited.pop_front();
            cmp("token_kind", 64'(want.kind), 64'(got.kind));
            cmp("start_offset", 64'(want.start), 64'(got.start));
            cmp("length", 64'(want.len), 64'(got.len));
            cmp("int_value", 64'(want.val), 64'(got.val));
            cmp("error_code", 64'(want.err), 64'(got.err));
            cmp("last_of_run", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_kind;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_token_kind;
    logic [31:0] o_start_offset;
    logic [31:0] o_length;
    logic [62:0] o_int_value;
    logic [1:0]  o_error_code;
    logic        o_last_of_run;

    token_scoreboard sb;
    logic [7:0]      src [$];
    bit              last_numeric;
    bit              send_calm;
    bit              recv_calm;
    int              items_sent;
    int              tokens_seen;

    c_subset_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_length       (o_length),
        .o_int_value    (o_int_value),
        .o_error_code   (o_error_code),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Source text builders
    function automatic void add_byte(logic [7:0] b);
        src.insert(src.size(), b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void put_digits(int n);
        repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return 8'h5F;
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    // lower or upper case exponent mark
    function automatic void put_exp_mark();
        add_byte($urandom_range(0, 1) ? 8'h65 : 8'h45);
    endfunction

    function automatic void put_exponent();
        put_exp_mark();
        case ($urandom_range(0, 2))
            0: put_text("+");
            1: put_text("-");
            default: ;
        endcase
        put_digits($urandom_range(1, 3));
    endfunction

    function automatic bit is_lexeme_start(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13) || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c inside {"(", ")", "{", "}", ";", ",", "+", "-", "*", "/", "=", "<", ">",
                         "!", ".", "_"};
    endfunction

    // Append one well-formed token and up to two whitespace bytes
    function automatic void add_token();
        string ops [8] = '{"/", "=", "==", "!=", "<", "<=", ">", ">="};
        string singles;
        string kw;
        int at;
        logic [7:0] b;
        bit numeric;
        singles = "(){};,+-*";
        at = src.size();
        numeric = 1'b0;
        case ($urandom_range(0, 11))
            0, 1: put_text(sb.keywords[$urandom_range(0, cts_pkg::KW_COUNT - 1)]);
            2: begin
                // near misses: a keyword cut short or one character too long
                kw = sb.keywords[$urandom_range(0, cts_pkg::KW_COUNT - 1)];
                if ($urandom_range(0, 1)) put_text(kw.substr(0, kw.len() - 2));
                else begin
                    put_text(kw);
                    add_byte(word_char());
                end
            end
            3, 4: begin
                do b = word_char(); while (b >= "0" && b <= "9");
                add_byte(b);
                repeat ($urandom_range(0, 8)) add_byte(word_char());
            end
            5, 6: begin
                numeric = 1'b1;
                case ($urandom_range(0, 5))
                    0: put_text("0");
                    1: put_text("9223372036854775807");
                    2: put_text("9223372036854775808");
                    3: put_digits($urandom_range(17, 24));
                    default: put_digits($urandom_range(1, 4));
                endcase
            end
            7: begin
                numeric = 1'b1;
                case ($urandom_range(0, 3))
                    0: begin
                        put_digits($urandom_range(1, 3));
                        put_text(".");
                        put_digits($urandom_range(0, 3));
                    end
                    1: begin
                        put_text(".");
                        put_digits($urandom_range(1, 3));
                    end
                    2: begin
                        put_digits($urandom_range(1, 3));
                        if ($urandom_range(0, 1)) begin
                            put_text(".");
                            put_digits($urandom_range(0, 2));
                        end
                        put_exponent();
                    end
                    default: begin
                        put_text(".");
                        put_digits($urandom_range(1, 2));
                        put_exponent();
                    end
                endcase
            end
            8, 9: add_byte(singles[$urandom_range(0, 8)]);
            10: put_text(ops[$urandom_range(0, 7)]);
            default: begin
                // comment body of any byte but newline and zero
                put_text("//");
                repeat ($urandom_range(0, 12)) begin
                    do b = 8'($urandom_range(1, 255)); while (b == 8'h0A);
                    add_byte(b);
                end
                put_text("\n");
            end
        endcase
        // keep a number from taking a following e or E as its exponent
        if (last_numeric && (src[at] == "e" || src[at] == "E")) src.insert(at, 8'h20);
        last_numeric = numeric;
        repeat ($urandom_range(0, 2)) begin
            add_byte(space_char());
            last_numeric = 1'b0;
        end
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(bit k, logic [7:0] c);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = k;
        i_ch = c;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(k, c);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send the built source, closed by a zero byte or an end item
    task automatic send_source(bit zero_end);
        foreach (src[i]) send_item(1'b0, src[i]);
        src.delete();
        last_numeric = 1'b0;
        if (zero_end) send_item(1'b0, 8'h00);
        else send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [7:0] b;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_ch = 8'h00;
        items_sent = 0;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: operators, a dot float with signed exponent, comment with a high byte,
        // a saturating integer, zero byte as end, then an empty source
        put_text("_a!=.5E-2;//");
        add_byte(8'hFF);
        put_text("\n99999999999999999999");
        send_source(1'b1);
        send_item(1'b1, 8'hA5);

        // random well-formed sources
        while (items_sent < 1500) begin
            repeat ($urandom_range(1, 30)) add_token();
            send_source($urandom_range(0, 4) == 0);
        end

        // close with one malformed token; the scanner stays failed from then on
        repeat (3) add_token();
        add_byte(8'h20);
        case ($urandom_range(0, 5))
            0: begin
                do b = 8'($urandom_range(1, 255)); while (is_lexeme_start(b));
                add_byte(b);
            end
            1: begin
                put_text("!");
                do b = 8'($urandom_range(0, 255)); while (b == "=");
                add_byte(b);
            end
            2: begin
                put_text(".");
                do b = 8'($urandom_range(0, 255)); while (b >= "0" && b <= "9");
                add_byte(b);
            end
            3: begin
                put_digits($urandom_range(1, 3));
                put_exp_mark();
                do b = 8'($urandom_range(0, 255));
                while ((b >= "0" && b <= "9") || b == "+" || b == "-");
                add_byte(b);
            end
            4: begin
                put_digits($urandom_range(1, 3));
                put_exp_mark();
                put_text($urandom_range(0, 1) ? "+" : "-");
                do b = 8'($urandom_range(0, 255)); while (b >= "0" && b <= "9");
                add_byte(b);
            end
            default: begin
                put_digits($urandom_range(1, 3));
                put_exp_mark();
            end
        endcase
        send_source(1'($urandom_range(0, 1)));
        repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        i_valid = 1'b0;

        // drain, then watch for stray tokens
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Token receiver: random stalls, one long hold-off to back up the input
    initial begin
        int gap;
        cts_pkg::t_result got;
        i_ready = 1'b0;
        tokens_seen = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 10);
            if (tokens_seen == 150) gap = 300;
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.kind = o_token_kind;
            got.start = o_start_offset;
            got.len = o_length;
            got.val = o_int_value;
            got.err = o_error_code;
            got.last = o_last_of_run;
            sb.check_token(got);
            tokens_seen++;
            @(negedge i_clk);
        end
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
